[src/rdpr_pkg.sv]
// Package with the shared types and constants of the remote debug packet receiver.
`default_nettype none

package rdpr_pkg;

  // Framing phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_BODY  = 5'b00010,
    PH_COUNT = 5'b00100,
    PH_CKHI  = 5'b01000,
    PH_CKLO  = 5'b10000
  } phase_t;

  // Status codes reported at packet end
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_CKSUM  = 3'd1,
    ERR_HEX    = 3'd2,
    ERR_NOPREV = 3'd3,
    ERR_OVER   = 3'd4
  } err_t;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Framing characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_TERM  = 8'h23;  // '#'
  localparam logic [7:0] CH_RUN   = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] HEX_LC_OFS = 8'h57;

  // Run count bias
  localparam logic [7:0] RUN_BIAS = 8'd29;

  // Reset value of the length limit
  localparam logic [15:0] MAX_LEN_RST = 16'd600;

endpackage

`default_nettype wire

[src/remote_debug_packet_receiver_unit.sv]
// Top level of the remote debug packet receiver: framing, checksum and run decode.
`default_nettype none

// Receives one character per beat, frames '$' body '#' hh packets, sums the body
// modulo 256 and checks it against the two lower-case hex digits. Each body byte
// yields a data-run result with one copy; '*' plus a count byte yields a run of
// (count-29) mod 256 copies of the previous byte. The second checksum digit yields a
// packet-end result with checksum_ok and the first error of the packet. A '$' anywhere
// restarts the packet; bytes outside a packet are dropped. One character is taken
// every clock cycle while the result register is free or emptying: the byte sits in
// an input register, and the framing state and the result register update from it
// when it advances. While a result waits on out_ready, one more character is held
// in the input register and then in_ready drops. The length limit
// (cfg_wr_data, reset 600) must be changed only while no beat is in flight.
module remote_debug_packet_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_repeat_res,
  output logic             out_checksum_ok,
  output logic [2:0]       out_status,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import rdpr_pkg::*;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       adv;

  // Config
  logic [15:0] max_len_r;

  // Framing state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [3:0]  ck_hi_r, ck_hi_nxt;
  logic [15:0] len_r, len_nxt;
  err_t        err_r, err_nxt;
  logic        dig_bad_r, dig_bad_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic        ck_ok_r, ck_ok_nxt;
  err_t        stat_r, stat_nxt;

  // Helpers
  logic        res_ld;
  logic [7:0]  add_n;
  logic [16:0] len_sum;
  logic [15:0] len_sat;
  logic        len_over;
  logic [3:0]  hex_val;
  logic        hex_bad;
  logic [7:0]  rx_ck;
  logic        ck_ok;
  err_t        err_hex;

  function automatic err_t note_err(input err_t cur, input err_t code);
    note_err = (cur == ERR_NONE) ? code : cur;
  endfunction

  // Handshake: stage 1 drains whenever the result register is free or emptying
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Hex digit decode of the current byte
  always_comb begin
    hex_bad = 1'b0;
    hex_val = 4'd0;
    if (s1_byte_r >= CH_LA && s1_byte_r <= CH_LF) begin
      hex_val = 4'(s1_byte_r - HEX_LC_OFS);
    end else if (s1_byte_r >= CH_ZERO && s1_byte_r <= CH_NINE) begin
      hex_val = 4'(s1_byte_r - CH_ZERO);
    end else begin
      hex_bad = 1'b1;
    end
  end

  // Saturating length update, shared by plain bytes and runs
  assign add_n    = (phase_r == PH_COUNT) ? (s1_byte_r - RUN_BIAS) : 8'd1;
  assign len_sum  = {1'b0, len_r} + {9'd0, add_n};
  assign len_sat  = len_sum[16] ? 16'hFFFF : len_sum[15:0];
  assign len_over = len_sat > max_len_r;

  // Checksum compare at the low digit
  assign err_hex = hex_bad ? note_err(err_r, ERR_HEX) : err_r;
  assign rx_ck   = {ck_hi_r, hex_val};
  assign ck_ok   = !(dig_bad_r || hex_bad) && (rx_ck == sum_r);

  // Per-byte framing step
  always_comb begin
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    ck_hi_nxt     = ck_hi_r;
    len_nxt       = len_r;
    err_nxt       = err_r;
    dig_bad_nxt   = dig_bad_r;
    res_ld        = 1'b0;
    kind_nxt      = KIND_DATA;
    data_nxt      = 8'd0;
    rep_nxt       = 8'd0;
    ck_ok_nxt     = 1'b0;
    stat_nxt      = ERR_NONE;

    if (s1_byte_r == CH_START) begin
      // restart a packet
      phase_nxt     = PH_BODY;
      sum_nxt       = 8'd0;
      prev_nxt      = 8'd0;
      have_prev_nxt = 1'b0;
      ck_hi_nxt     = 4'd0;
      len_nxt       = 16'd0;
      err_nxt       = ERR_NONE;
      dig_bad_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_BODY: begin
          if (s1_byte_r == CH_TERM) begin
            phase_nxt = PH_CKHI;
          end else if (s1_byte_r == CH_RUN) begin
            sum_nxt   = sum_r + s1_byte_r;
            phase_nxt = PH_COUNT;
            if (!have_prev_r) begin
              err_nxt = note_err(err_r, ERR_NOPREV);
            end
          end else begin
            sum_nxt       = sum_r + s1_byte_r;
            prev_nxt      = s1_byte_r;
            have_prev_nxt = 1'b1;
            len_nxt       = len_sat;
            if (len_over) begin
              err_nxt = note_err(err_r, ERR_OVER);
            end
            res_ld   = 1'b1;
            data_nxt = s1_byte_r;
            rep_nxt  = 8'd1;
          end
        end
        PH_COUNT: begin
          sum_nxt   = sum_r + s1_byte_r;
          phase_nxt = PH_BODY;
          if (have_prev_r) begin
            len_nxt = len_sat;
            if (len_over) begin
              err_nxt = note_err(err_r, ERR_OVER);
            end
            res_ld   = 1'b1;
            data_nxt = prev_r;
            rep_nxt  = add_n;
          end
        end
        PH_CKHI: begin
          ck_hi_nxt = hex_val;
          phase_nxt = PH_CKLO;
          if (hex_bad) begin
            dig_bad_nxt = 1'b1;
            err_nxt     = err_hex;
          end
        end
        PH_CKLO: begin
          if (hex_bad) begin
            dig_bad_nxt = 1'b1;
          end
          err_nxt   = ck_ok ? err_hex : note_err(err_hex, ERR_CKSUM);
          phase_nxt = PH_IDLE;
          res_ld    = 1'b1;
          kind_nxt  = KIND_END;
          ck_ok_nxt = ck_ok;
          stat_nxt  = ck_ok ? err_hex : note_err(err_hex, ERR_CKSUM);
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Framing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sum_r       <= 8'd0;
      prev_r      <= 8'd0;
      have_prev_r <= 1'b0;
      ck_hi_r     <= 4'd0;
      len_r       <= 16'd0;
      err_r       <= ERR_NONE;
      dig_bad_r   <= 1'b0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      ck_hi_r     <= ck_hi_nxt;
      len_r       <= len_nxt;
      err_r       <= err_nxt;
      dig_bad_r   <= dig_bad_nxt;
    end
  end

  // Result register
  always_comb begin
    if (adv && res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_ld) begin
      kind_r  <= kind_nxt;
      data_r  <= data_nxt;
      rep_r   <= rep_nxt;
      ck_ok_r <= ck_ok_nxt;
      stat_r  <= stat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_data_byte   = data_r;
  assign out_repeat_res  = rep_r;
  assign out_checksum_ok = ck_ok_r;
  assign out_status      = stat_r;

endmodule

`default_nettype wire

[src/rdpr_checker.sv]
// Port-level checker for the remote debug packet receiver, with its bind.
`default_nettype none

module rdpr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_data_byte,
  input wire logic [7:0]  out_repeat_res,
  input wire logic        out_checksum_ok,
  input wire logic [2:0]  out_status
);
  import rdpr_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_repeat_res) &&
      $stable(out_checksum_ok) && $stable(out_status))
    else $error("result beat changed while stalled");

  // Only data runs and packet ends are produced
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_END))
    else $error("bad result kind");

  // Data runs carry no packet status
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> !out_checksum_ok && out_status == ERR_NONE)
    else $error("data run with status");

  // A matched checksum never reports a digit or checksum error; a mismatch always
  // reports some error
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |->
      (out_checksum_ok ? (out_status != ERR_CKSUM && out_status != ERR_HEX)
                       : (out_status != ERR_NONE)))
    else $error("checksum_ok disagrees with status");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind remote_debug_packet_receiver_unit rdpr_checker u_rdpr_checker (.*);

`default_nettype wire
